// ===== sv/nlsp_pkg.sv =====
// shared constants and types for the normalised linear stereo pan
package nlsp_pkg;

    localparam int SAMPLE_BITS = 24;

    // pan level is unsigned q0.24 with 1.0 allowed
    localparam int LEVEL_W = 25;
    localparam logic [LEVEL_W-1:0] ONE_Q24 = LEVEL_W'(1 << 24);

    localparam int FC_W   = 16;
    localparam int STEP_W = 25;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 25;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAN_STEP    = 1'd1;

    localparam logic [FC_W-1:0]   FRAME_COUNT_RST = FC_W'(48000);
    localparam logic [STEP_W-1:0] PAN_STEP_RST    = STEP_W'(350);

    // l^2 + r^2 fits in 49 bits, held in an even width for the root
    localparam int RAD_W  = 2 * LEVEL_W;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    // gains are unsigned q0.23 with 1.0 allowed
    localparam int GAIN_FRAC = 23;
    localparam int GAIN_W    = GAIN_FRAC + 1;
    localparam int PROD_W    = SAMPLE_BITS + GAIN_W + 1;

    localparam int ROOT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = GAIN_W;
    localparam int CNT_W      = $clog2(ROOT_STEPS);

    typedef struct packed {
        logic load;
        logic square;
        logic root_load;
        logic root_step;
        logic div_load;
        logic div_step;
        logic scale;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

// ===== sv/nlsp_ctrl.sv =====
// sequencer for the pan: squares, root iterations, divide iterations, scaling
module nlsp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  nlsp_pkg::status_t status,
    output nlsp_pkg::cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_SQUARE    = 7'b0000010,
        ST_ROOT_LOAD = 7'b0000100,
        ST_ROOT      = 7'b0001000,
        ST_DIV_LOAD  = 7'b0010000,
        ST_DIV       = 7'b0100000,
        ST_SCALE     = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [nlsp_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                state_next = ST_ROOT_LOAD;
            end
            ST_ROOT_LOAD: begin
                state_next = ST_ROOT;
                cnt_next   = '0;
            end
            ST_ROOT: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == nlsp_pkg::CNT_W'(nlsp_pkg::ROOT_STEPS - 1)) begin
                    state_next = ST_DIV_LOAD;
                end
            end
            ST_DIV_LOAD: begin
                state_next = ST_DIV;
                cnt_next   = '0;
            end
            ST_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == nlsp_pkg::CNT_W'(nlsp_pkg::DIV_STEPS - 1)) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                // hold until the output register can take the beat
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd.load      = (state_reg == ST_IDLE) && s_valid;
        cmd.square    = (state_reg == ST_SQUARE);
        cmd.root_load = (state_reg == ST_ROOT_LOAD);
        cmd.root_step = (state_reg == ST_ROOT);
        cmd.div_load  = (state_reg == ST_DIV_LOAD);
        cmd.div_step  = (state_reg == ST_DIV);
        cmd.scale     = (state_reg == ST_SCALE) && status.out_free;
    end

endmodule

// ===== sv/nlsp_datapath.sv =====
// pan datapath: level state, squares, bit-serial root, two dividers, output scaling
module nlsp_datapath (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  nlsp_pkg::cmd_t                           cmd,
    output nlsp_pkg::status_t                        status,
    input  logic                                     cfg_we,
    input  logic [nlsp_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [nlsp_pkg::CFG_DATA_W-1:0]          cfg_wdata,
    input  logic signed [nlsp_pkg::SAMPLE_BITS-1:0]  s_sample,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic signed [nlsp_pkg::SAMPLE_BITS-1:0]  m_left_sample,
    output logic signed [nlsp_pkg::SAMPLE_BITS-1:0]  m_right_sample,
    output logic                                     m_pan_done
);

    localparam int LW = nlsp_pkg::LEVEL_W;
    localparam int GW = nlsp_pkg::GAIN_W;
    localparam int SB = nlsp_pkg::SAMPLE_BITS;

    // configuration and sweep state
    logic [nlsp_pkg::FC_W-1:0]   frame_count_reg;
    logic [nlsp_pkg::STEP_W-1:0] pan_step_reg;
    logic [LW-1:0]               pan_level_reg, pan_level_next;
    logic [nlsp_pkg::FC_W-1:0]   frame_pos_reg, frame_pos_next;

    // working registers
    logic signed [SB-1:0]           sample_reg;
    logic [nlsp_pkg::RAD_W-1:0]     lsq_reg, rsq_reg;
    logic [nlsp_pkg::RAD_W-1:0]     rad_reg, rad_next;
    logic [nlsp_pkg::REM_W-1:0]     rem_reg, rem_next;
    logic [nlsp_pkg::ROOT_W-1:0]    root_reg, root_next;
    logic [LW-1:0]                  drem_l_reg, drem_l_next, drem_r_reg, drem_r_next;
    logic [GW-1:0]                  num_l_reg, num_r_reg;
    logic [GW-1:0]                  gain_l_reg, gain_l_next, gain_r_reg, gain_r_next;

    logic                           m_valid_reg;
    logic signed [SB-1:0]           left_reg, right_reg;
    logic                           done_reg;

    logic [LW-1:0] lvl;
    logic [LW-1:0] rvl;

    always_comb begin
        lvl = (pan_level_reg > nlsp_pkg::ONE_Q24) ? nlsp_pkg::ONE_Q24 : pan_level_reg;
        rvl = nlsp_pkg::ONE_Q24 - lvl;
    end

    // one root digit per cycle
    logic [nlsp_pkg::REM_W+1:0] rem_shift;
    logic [nlsp_pkg::REM_W+1:0] trial;

    always_comb begin
        rem_shift = {rem_reg, rad_reg[nlsp_pkg::RAD_W-1 -: 2]};
        trial     = (nlsp_pkg::REM_W + 2)'({root_reg, 2'b01});
        rad_next  = rad_reg << 2;
        if (rem_shift >= trial) begin
            rem_next  = nlsp_pkg::REM_W'(rem_shift - trial);
            root_next = {root_reg[nlsp_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            rem_next  = nlsp_pkg::REM_W'(rem_shift);
            root_next = {root_reg[nlsp_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    // one quotient bit per cycle for each gain, shared divisor
    logic [LW:0] dshift_l, dshift_r, divisor;

    always_comb begin
        divisor  = (LW + 1)'(root_reg);
        dshift_l = {drem_l_reg, num_l_reg[GW-1]};
        dshift_r = {drem_r_reg, num_r_reg[GW-1]};
        if (dshift_l >= divisor) begin
            drem_l_next = LW'(dshift_l - divisor);
            gain_l_next = {gain_l_reg[GW-2:0], 1'b1};
        end else begin
            drem_l_next = LW'(dshift_l);
            gain_l_next = {gain_l_reg[GW-2:0], 1'b0};
        end
        if (dshift_r >= divisor) begin
            drem_r_next = LW'(dshift_r - divisor);
            gain_r_next = {gain_r_reg[GW-2:0], 1'b1};
        end else begin
            drem_r_next = LW'(dshift_r);
            gain_r_next = {gain_r_reg[GW-2:0], 1'b0};
        end
    end

    // scaling and sweep update
    logic signed [nlsp_pkg::PROD_W-1:0] prod_l, prod_r;
    logic                               done;

    always_comb begin
        prod_l = sample_reg * $signed({1'b0, gain_l_reg});
        prod_r = sample_reg * $signed({1'b0, gain_r_reg});
        done   = (frame_count_reg <= nlsp_pkg::FC_W'(1))
              || (frame_pos_reg >= frame_count_reg - 1'b1);
        if (done) begin
            frame_pos_next = '0;
            pan_level_next = nlsp_pkg::ONE_Q24;
        end else begin
            frame_pos_next = frame_pos_reg + 1'b1;
            pan_level_next = (LW'(pan_step_reg) >= lvl) ? '0 : lvl - LW'(pan_step_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_count_reg <= nlsp_pkg::FRAME_COUNT_RST;
            pan_step_reg    <= nlsp_pkg::PAN_STEP_RST;
            pan_level_reg   <= nlsp_pkg::ONE_Q24;
            frame_pos_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    nlsp_pkg::CFG_FRAME_COUNT: frame_count_reg <= cfg_wdata[nlsp_pkg::FC_W-1:0];
                    nlsp_pkg::CFG_PAN_STEP:    pan_step_reg    <= cfg_wdata[nlsp_pkg::STEP_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.scale) begin
                pan_level_reg <= pan_level_next;
                frame_pos_reg <= frame_pos_next;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sample_reg <= s_sample;
        end
        if (cmd.square) begin
            lsq_reg <= nlsp_pkg::RAD_W'(lvl) * nlsp_pkg::RAD_W'(lvl);
            rsq_reg <= nlsp_pkg::RAD_W'(rvl) * nlsp_pkg::RAD_W'(rvl);
        end
        if (cmd.root_load) begin
            rad_reg  <= lsq_reg + rsq_reg;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cmd.root_step) begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
        if (cmd.div_load) begin
            // high part of level * 2^23 is already below the root
            drem_l_reg <= lvl >> 1;
            drem_r_reg <= rvl >> 1;
            num_l_reg  <= {lvl[0], {(GW-1){1'b0}}};
            num_r_reg  <= {rvl[0], {(GW-1){1'b0}}};
            gain_l_reg <= '0;
            gain_r_reg <= '0;
        end else if (cmd.div_step) begin
            drem_l_reg <= drem_l_next;
            drem_r_reg <= drem_r_next;
            num_l_reg  <= num_l_reg << 1;
            num_r_reg  <= num_r_reg << 1;
            gain_l_reg <= gain_l_next;
            gain_r_reg <= gain_r_next;
        end
        if (cmd.scale) begin
            left_reg  <= prod_l[SB+nlsp_pkg::GAIN_FRAC-1:nlsp_pkg::GAIN_FRAC];
            right_reg <= prod_r[SB+nlsp_pkg::GAIN_FRAC-1:nlsp_pkg::GAIN_FRAC];
            done_reg  <= done;
        end
    end

    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_left_sample   = left_reg;
    assign m_right_sample  = right_reg;
    assign m_pan_done      = done_reg;

endmodule

// ===== sv/normalized_linear_stereo_pan_top.sv =====
// top level of the normalised linear stereo pan
// each sample passes the squares, the 25-step square root and the 24-step gain division,
// both one bit per cycle, before its result beat is registered; a new sample is
// taken only once the sequencer is back in idle
// the output register lets the next sample in while a result beat waits
// reset (aresetn low, synchronous) clears the sweep to full left, position zero
module normalized_linear_stereo_pan_top (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     cfg_we,
    input  logic [nlsp_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [nlsp_pkg::CFG_DATA_W-1:0]          cfg_wdata,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic signed [nlsp_pkg::SAMPLE_BITS-1:0]  s_sample,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic signed [nlsp_pkg::SAMPLE_BITS-1:0]  m_left_sample,
    output logic signed [nlsp_pkg::SAMPLE_BITS-1:0]  m_right_sample,
    output logic                                     m_pan_done
);

    nlsp_pkg::cmd_t    cmd;
    nlsp_pkg::status_t status;

    nlsp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    nlsp_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_sample       (s_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_left_sample  (m_left_sample),
        .m_right_sample (m_right_sample),
        .m_pan_done     (m_pan_done)
    );

endmodule

// ===== sv/nlsp_checker.sv =====
// port checks for the stereo pan, bound to the top level
module nlsp_checker (
    input logic                                     aclk,
    input logic                                     aresetn,
    input logic                                     s_valid,
    input logic                                     s_ready,
    input logic                                     m_valid,
    input logic                                     m_ready,
    input logic signed [nlsp_pkg::SAMPLE_BITS-1:0]  m_left_sample,
    input logic signed [nlsp_pkg::SAMPLE_BITS-1:0]  m_right_sample,
    input logic                                     m_pan_done
);

    // one sample in flight: no second beat straight after a taken one
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken again while a sample is in work");

    // a fresh result coincides with the sequencer going back to idle
    a_ready_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result raised without the input side reopening");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(m_left_sample) && $stable(m_right_sample)
                                   && $stable(m_pan_done)))
        else $error("result beat changed while stalled");

endmodule

bind normalized_linear_stereo_pan_top nlsp_checker u_nlsp_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_left_sample  (m_left_sample),
    .m_right_sample (m_right_sample),
    .m_pan_done     (m_pan_done)
);

// ===== bench/testbench.sv =====
// self-checking bench for the normalised linear stereo pan: predicted pairs against result beats
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1250;
    localparam int MAX_GAP      = 18;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 600000;

    typedef struct {
        logic signed [nlsp_pkg::SAMPLE_BITS-1:0] left;
        logic signed [nlsp_pkg::SAMPLE_BITS-1:0] right;
        logic                                    done;
    } pan_pair_t;

    class pan_scoreboard;
        logic [nlsp_pkg::LEVEL_W-1:0] level;
        logic [nlsp_pkg::FC_W-1:0]    position;
        logic [nlsp_pkg::FC_W-1:0]    frame_len;
        logic [nlsp_pkg::STEP_W-1:0]  step;
        pan_pair_t                    pairs_due[$];
        int                           mismatches;
        int                           beats_checked;
        int                           sweep_ends;

        function new();
            frame_len     = nlsp_pkg::FRAME_COUNT_RST;
            step          = nlsp_pkg::PAN_STEP_RST;
            level         = nlsp_pkg::ONE_Q24;
            position      = '0;
            mismatches    = 0;
            beats_checked = 0;
            sweep_ends    = 0;
        endfunction

        function void write_reg(logic [nlsp_pkg::CFG_IDX_W-1:0] idx,
                                logic [nlsp_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                nlsp_pkg::CFG_FRAME_COUNT: frame_len = data[nlsp_pkg::FC_W-1:0];
                nlsp_pkg::CFG_PAN_STEP:    step = data[nlsp_pkg::STEP_W-1:0];
                default: ;
            endcase
        endfunction

        // bit-serial integer square root, floor
        function logic [63:0] square_root(logic [63:0] v);
            logic [63:0] root;
            logic [63:0] probe;
            logic [63:0] rest;
            root  = '0;
            probe = 64'd1 << 62;
            rest  = v;
            while (probe > rest)
                probe = probe >> 2;
            while (probe != 0) begin
                if (rest >= root + probe) begin
                    rest = rest - (root + probe);
                    root = (root >> 1) + probe;
                end else begin
                    root = root >> 1;
                end
                probe = probe >> 2;
            end
            return root;
        endfunction

        // floor(x * g / 2^23) kept to the sample width
        function logic signed [nlsp_pkg::SAMPLE_BITS-1:0] scaled(
                logic signed [nlsp_pkg::SAMPLE_BITS-1:0] x, logic [63:0] g);
            longint prod;
            prod = longint'(x) * longint'(g);
            prod = prod >>> nlsp_pkg::GAIN_FRAC;
            return prod[nlsp_pkg::SAMPLE_BITS-1:0];
        endfunction

        function void take_sample(logic signed [nlsp_pkg::SAMPLE_BITS-1:0] x);
            logic [63:0] l;
            logic [63:0] r;
            logic [63:0] norm;
            logic [63:0] gain_l;
            logic [63:0] gain_r;
            logic        done;
            pan_pair_t   pair;
            l      = (level > nlsp_pkg::ONE_Q24) ? 64'(nlsp_pkg::ONE_Q24) : 64'(level);
            r      = 64'(nlsp_pkg::ONE_Q24) - l;
            norm   = square_root(l * l + r * r);
            gain_l = (l << nlsp_pkg::GAIN_FRAC) / norm;
            gain_r = (r << nlsp_pkg::GAIN_FRAC) / norm;
            done   = (frame_len <= 1) || (position >= frame_len - 1'b1);
            pair.left  = scaled(x, gain_l);
            pair.right = scaled(x, gain_r);
            pair.done  = done;
            pairs_due.push_back(pair);
            if (done) begin
                position = '0;
                level    = nlsp_pkg::ONE_Q24;
            end else begin
                position = position + 1'b1;
                level    = (64'(step) >= l) ? '0 : nlsp_pkg::LEVEL_W'(l - 64'(step));
            end
        endfunction

        function void check_pair(logic signed [nlsp_pkg::SAMPLE_BITS-1:0] left,
                                 logic signed [nlsp_pkg::SAMPLE_BITS-1:0] right,
                                 logic done);
            pan_pair_t want;
            if (pairs_due.size() == 0) begin
                $error("result beat with no sample outstanding: left %0d right %0d done %0d",
                       left, right, done);
                mismatches++;
                return;
            end
            want = pairs_due.pop_front();
            beats_checked++;
            if (done)
                sweep_ends++;
            if (left !== want.left) begin
                $error("left_sample: expected %0d, actual %0d", want.left, left);
                mismatches++;
            end
            if (right !== want.right) begin
                $error("right_sample: expected %0d, actual %0d", want.right, right);
                mismatches++;
            end
            if (done !== want.done) begin
                $error("pan_done: expected %0d, actual %0d", want.done, done);
                mismatches++;
            end
        endfunction
    endclass

    logic                                    aclk = 1'b0;
    logic                                    aresetn = 1'b0;
    logic                                    cfg_we = 1'b0;
    logic [nlsp_pkg::CFG_IDX_W-1:0]          cfg_index = '0;
    logic [nlsp_pkg::CFG_DATA_W-1:0]         cfg_wdata = '0;
    logic                                    s_valid = 1'b0;
    logic                                    s_ready;
    logic signed [nlsp_pkg::SAMPLE_BITS-1:0] s_sample = '0;
    logic                                    m_valid;
    logic                                    m_ready = 1'b0;
    logic signed [nlsp_pkg::SAMPLE_BITS-1:0] m_left_sample;
    logic signed [nlsp_pkg::SAMPLE_BITS-1:0] m_right_sample;
    logic                                    m_pan_done;

    pan_scoreboard sb = new();
    logic          no_idle = 1'b0;
    logic          hold_rx = 1'b0;
    int            cycles = 0;
    int            settings_used = 0;

    normalized_linear_stereo_pan_top u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_left_sample (m_left_sample),
        .m_right_sample(m_right_sample),
        .m_pan_done    (m_pan_done)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pairs outstanding", cycles,
                     sb.pairs_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // writes both registers back to back, frame count then pan step
    task automatic set_pan(input logic [nlsp_pkg::CFG_DATA_W-1:0] fc_word,
                           input logic [nlsp_pkg::CFG_DATA_W-1:0] step_word);
        cfg_we    <= 1'b1;
        cfg_index <= nlsp_pkg::CFG_FRAME_COUNT;
        cfg_wdata <= fc_word;
        @(posedge aclk);
        cfg_index <= nlsp_pkg::CFG_PAN_STEP;
        cfg_wdata <= step_word;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.write_reg(nlsp_pkg::CFG_FRAME_COUNT, fc_word);
        sb.write_reg(nlsp_pkg::CFG_PAN_STEP, step_word);
        settings_used++;
    endtask

    task automatic send_sample(input logic signed [nlsp_pkg::SAMPLE_BITS-1:0] x);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= x;
        do @(posedge aclk); while (!s_ready);
        sb.take_sample(x);
    endtask

    // stop offering and wait for every outstanding pair
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pairs_due.size() != 0)
            @(posedge aclk);
    endtask

    function automatic logic signed [nlsp_pkg::SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 15))
            0:       return {1'b0, {(nlsp_pkg::SAMPLE_BITS-1){1'b1}}};
            1:       return {1'b1, {(nlsp_pkg::SAMPLE_BITS-1){1'b0}}};
            2:       return '0;
            3:       return '1;
            default: return nlsp_pkg::SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [nlsp_pkg::CFG_DATA_W-1:0] matched_step(int unsigned fc);
        return nlsp_pkg::CFG_DATA_W'(((32'd1 << 24) + (fc - 1) / 2) / (fc - 1));
    endfunction

    // receiver: random stalls, one long hold-off on request
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_rx) begin
                hold_rx = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_pair(m_left_sample, m_right_sample, m_pan_done);
        end
    end

    initial begin
        int sent;
        int phase;
        int count;
        int unsigned fc;
        logic [nlsp_pkg::CFG_DATA_W-1:0] fc_word;
        logic [nlsp_pkg::CFG_DATA_W-1:0] step_word;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings, extremes of the sample starting from full left
        send_sample({1'b0, {(nlsp_pkg::SAMPLE_BITS-1){1'b1}}});
        send_sample({1'b1, {(nlsp_pkg::SAMPLE_BITS-1){1'b0}}});
        send_sample('0);
        send_sample('1);
        send_sample(nlsp_pkg::SAMPLE_BITS'(1));
        drain();
        // short sweep: every frame ends it
        set_pan(nlsp_pkg::CFG_DATA_W'(1), nlsp_pkg::CFG_DATA_W'(350));
        repeat (2) send_sample(pick_sample());
        drain();
        set_pan('0, '0);
        repeat (2) send_sample(pick_sample());
        drain();
        // step beyond the level drops straight to full right
        set_pan(nlsp_pkg::CFG_DATA_W'(65535), '1);
        repeat (3) send_sample({1'b0, {(nlsp_pkg::SAMPLE_BITS-1){1'b1}}});
        drain();
        // position now past the shortened end
        set_pan(nlsp_pkg::CFG_DATA_W'(2), nlsp_pkg::CFG_DATA_W'(nlsp_pkg::ONE_Q24));
        repeat (3) send_sample({1'b1, {(nlsp_pkg::SAMPLE_BITS-1){1'b0}}});
        drain();
        // upper data bits ignored by the frame count, centre pan on the second frame
        set_pan(nlsp_pkg::CFG_DATA_W'(25'h1_0003), nlsp_pkg::CFG_DATA_W'(1 << 23));
        repeat (4) send_sample(pick_sample());
        drain();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    fc        = $urandom_range(2, 40);
                    fc_word   = nlsp_pkg::CFG_DATA_W'(fc);
                    step_word = matched_step(fc);
                end
                6: begin
                    fc_word   = nlsp_pkg::CFG_DATA_W'($urandom_range(2, 65535));
                    step_word = nlsp_pkg::CFG_DATA_W'($urandom);
                end
                7: begin
                    fc_word   = nlsp_pkg::CFG_DATA_W'(65535);
                    step_word = matched_step(65535);
                end
                8: begin
                    fc_word   = nlsp_pkg::CFG_DATA_W'($urandom_range(0, 1));
                    step_word = nlsp_pkg::CFG_DATA_W'($urandom);
                end
                default: begin
                    fc_word   = nlsp_pkg::CFG_DATA_W'($urandom);
                    step_word = nlsp_pkg::CFG_DATA_W'($urandom_range(0, 1 << 24));
                end
            endcase
            set_pan(fc_word, step_word);
            no_idle = ($urandom_range(0, 4) == 0);
            count   = $urandom_range(20, 80);
            if (phase == 2) begin
                // receiver stalls long while samples keep coming back to back
                no_idle = 1'b1;
                hold_rx = 1'b1;
            end
            repeat (count) send_sample(pick_sample());
            sent += count;
            drain();
            phase++;
        end

        no_idle = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("%0d stereo beats checked over %0d register settings", sb.beats_checked,
                 settings_used);
        $display("%0d sweep ends seen, %0d mismatches", sb.sweep_ends, sb.mismatches);
        if (sb.mismatches == 0 && sb.pairs_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/nlsp_pkg.sv
sv/nlsp_ctrl.sv
sv/nlsp_datapath.sv
sv/normalized_linear_stereo_pan_top.sv
sv/nlsp_checker.sv
bench/testbench.sv
